[src/upr_pkg.sv]
// ---------------------------------------------------------------------------
// upr_pkg: shared types and constants of the unmatched parenthesis remover
// Sizes of the byte store and the open-parenthesis stack, character codes,
// sequencer states and the port groups that link the sequencer to the RAMs.
// ---------------------------------------------------------------------------
package upr_pkg;

    localparam int MAX_LEN = 1024;
    localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int DW      = 9;   // {removed mark, byte}

    localparam logic [7:0] OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CLOSE_PAREN = 8'h29;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN1,
        ST_SCAN2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_dmem_req;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [AW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_smem_req;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_kept;
        logic       none_left;
        logic       overflowed;
    } t_result;

endpackage

[src/unmatched_paren_remover_top.sv]
// ---------------------------------------------------------------------------
// unmatched_paren_remover_top: removes unbalanced parentheses from a string
//
// Slave channel: one transaction per item. tuser selects the action
// (0 = load the byte in tdata, 1 = fetch the next kept byte); tlast marks
// the final byte of a string on a load. A load gives no result; a fetch
// gives exactly one on the master channel: the kept byte in tdata, tlast
// set on the last kept byte, tuser carrying none-left and overflow flags.
// Loads are accepted back to back while the sequencer is idle. A final
// load with unmatched '(' pops the stack memory one entry a cycle and
// marks each popped position in the byte memory in the cycle after.
// A fetch on a finalised string scans the byte memory one entry a cycle
// through its single read port, once to find the kept byte and, if one
// is found, once more to find whether another follows.
// Reset clears lengths, stack depth and flags; the memories are not
// cleared, no entry is read before the current string wrote it.
// A stalled receiver holds the result in the output register; loads go on
// being accepted until one more fetch is accepted, which then waits in the
// sequencer, taking no further item, until the output register frees up.
// A load after a finalised string starts anew.
// ---------------------------------------------------------------------------
module unmatched_paren_remover_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic       i_s_tuser,   // [0] action
    input  logic       i_s_tlast,   // final_char
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] char_out
    output logic [1:0] o_m_tuser,   // [0] none_left, [1] overflowed
    output logic       o_m_tlast    // last_kept
);

    upr_pkg::t_dmem_req          dmem_req;
    upr_pkg::t_smem_req          smem_req;
    logic [upr_pkg::DW-1:0]      dmem_rdata;
    logic [upr_pkg::AW-1:0]      smem_rdata;
    logic                        res_valid;
    logic                        res_ready;
    upr_pkg::t_result            res;

    logic                        r_m_valid;
    upr_pkg::t_result            r_m_res;

    // byte store with removal mark in the top bit
    upr_ram #(
        .WIDTH(upr_pkg::DW),
        .DEPTH(upr_pkg::MAX_LEN)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (dmem_req.we),
        .i_waddr(dmem_req.waddr),
        .i_wdata(dmem_req.wdata),
        .i_raddr(dmem_req.raddr),
        .o_rdata(dmem_rdata)
    );

    // positions of open parentheses still unmatched
    upr_ram #(
        .WIDTH(upr_pkg::AW),
        .DEPTH(upr_pkg::MAX_LEN)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (smem_req.we),
        .i_waddr(smem_req.waddr),
        .i_wdata(smem_req.wdata),
        .i_raddr(smem_req.raddr),
        .o_rdata(smem_rdata)
    );

    upr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_char      (i_s_tdata),
        .i_final     (i_s_tlast),
        .o_dmem      (dmem_req),
        .i_dmem_rdata(dmem_rdata),
        .o_smem      (smem_req),
        .i_smem_rdata(smem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: take a new result whenever the slot is empty or drains
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_res.char_out;
    assign o_m_tlast    = r_m_res.last_kept;
    assign o_m_tuser[0] = r_m_res.none_left;
    assign o_m_tuser[1] = r_m_res.overflowed;

endmodule

[src/upr_ram.sv]
// ---------------------------------------------------------------------------
// upr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module upr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/upr_seq.sv]
// ---------------------------------------------------------------------------
// upr_seq: sequencer of the unmatched parenthesis remover
// Loads bytes and stack entries, drains the stack on the final byte and
// scans the removal marks to find kept bytes on a fetch.
// ---------------------------------------------------------------------------
module upr_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [7:0]           i_char,
    input  logic                 i_final,
    output upr_pkg::t_dmem_req   o_dmem,
    input  logic [upr_pkg::DW-1:0] i_dmem_rdata,
    output upr_pkg::t_smem_req   o_smem,
    input  logic [upr_pkg::AW-1:0] i_smem_rdata,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output upr_pkg::t_result     o_res
);

    upr_pkg::t_state r_state, n_state;

    logic [upr_pkg::CW-1:0] r_len,   n_len;
    logic [upr_pkg::CW-1:0] r_depth, n_depth;
    logic [upr_pkg::CW-1:0] r_ptr,   n_ptr;
    logic [upr_pkg::CW-1:0] r_next,  n_next;
    logic [upr_pkg::CW-1:0] r_pa,    n_pa;
    logic                   r_fin,   n_fin;
    logic                   r_ovf,   n_ovf;
    logic                   r_pv,    n_pv;
    logic                   r_drain_v, n_drain_v;
    upr_pkg::t_result       r_res,   n_res;

    logic                   s_acc;
    logic                   kept_hit;
    logic                   at_end;
    logic [upr_pkg::CW-1:0] len_e;
    logic [upr_pkg::CW-1:0] depth_e;
    logic [upr_pkg::CW-1:0] depth_dec;
    logic                   has_room;
    logic                   is_open;
    logic                   is_close;

    assign o_ready     = (r_state == upr_pkg::ST_IDLE);
    assign s_acc       = i_valid && o_ready;
    assign kept_hit    = r_pv && !i_dmem_rdata[upr_pkg::DW-1];
    assign at_end      = (r_next >= r_len);
    assign len_e       = r_fin ? '0 : r_len;
    assign depth_e     = r_fin ? '0 : r_depth;
    assign depth_dec   = r_depth - upr_pkg::CW'(1);
    assign has_room    = (len_e < upr_pkg::CW'(upr_pkg::MAX_LEN));
    assign is_open     = (i_char == upr_pkg::OPEN_PAREN);
    assign is_close    = (i_char == upr_pkg::CLOSE_PAREN);
    assign o_res_valid = (r_state == upr_pkg::ST_EMIT);
    assign o_res       = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            upr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (i_action == upr_pkg::ACT_LOAD) begin
                        if (i_final && (n_depth != '0)) begin
                            n_state = upr_pkg::ST_DRAIN;
                        end
                    end else if (r_fin) begin
                        n_state = upr_pkg::ST_SCAN1;
                    end else begin
                        n_state = upr_pkg::ST_EMIT;
                    end
                end
            end
            upr_pkg::ST_DRAIN: begin
                if ((r_depth == '0) && !r_drain_v) begin
                    n_state = upr_pkg::ST_IDLE;
                end
            end
            upr_pkg::ST_SCAN1: begin
                if (kept_hit) begin
                    n_state = upr_pkg::ST_SCAN2;
                end else if (at_end) begin
                    n_state = upr_pkg::ST_EMIT;
                end
            end
            upr_pkg::ST_SCAN2: begin
                if (kept_hit || at_end) begin
                    n_state = upr_pkg::ST_EMIT;
                end
            end
            upr_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = upr_pkg::ST_IDLE;
                end
            end
            default: n_state = upr_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_len     = r_len;
        n_depth   = r_depth;
        n_ptr     = r_ptr;
        n_next    = r_next;
        n_pa      = r_pa;
        n_fin     = r_fin;
        n_ovf     = r_ovf;
        n_pv      = r_pv;
        n_drain_v = r_drain_v;
        n_res     = r_res;

        o_dmem.we    = 1'b0;
        o_dmem.waddr = len_e[upr_pkg::AW-1:0];
        o_dmem.wdata = {is_close && (depth_e == '0), i_char};
        o_dmem.raddr = r_next[upr_pkg::AW-1:0];
        o_smem.we    = 1'b0;
        o_smem.waddr = depth_e[upr_pkg::AW-1:0];
        o_smem.wdata = len_e[upr_pkg::AW-1:0];
        o_smem.raddr = depth_dec[upr_pkg::AW-1:0];

        case (r_state)
            upr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (i_action == upr_pkg::ACT_LOAD) begin
                        // a load after finalise opens a fresh string
                        n_fin   = 1'b0;
                        n_len   = len_e;
                        n_depth = depth_e;
                        n_ptr   = r_fin ? '0 : r_ptr;
                        n_ovf   = r_fin ? 1'b0 : r_ovf;
                        if (has_room) begin
                            o_dmem.we = 1'b1;
                            n_len     = len_e + upr_pkg::CW'(1);
                            if (is_open) begin
                                if (depth_e < upr_pkg::CW'(upr_pkg::MAX_LEN)) begin
                                    o_smem.we = 1'b1;
                                    n_depth   = depth_e + upr_pkg::CW'(1);
                                end
                            end else if (is_close && (depth_e != '0)) begin
                                n_depth = depth_e - upr_pkg::CW'(1);
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_final) begin
                            n_ptr     = '0;
                            n_drain_v = 1'b0;
                            if (n_depth == '0) begin
                                n_fin = 1'b1;
                            end
                        end
                    end else begin
                        n_res.char_out   = '0;
                        n_res.last_kept  = 1'b0;
                        n_res.none_left  = 1'b1;
                        n_res.overflowed = r_ovf;
                        n_next           = r_ptr;
                        n_pv             = 1'b0;
                    end
                end
            end
            upr_pkg::ST_DRAIN: begin
                // pop one entry per cycle, mark the popped position in the cycle after
                if (r_depth != '0) begin
                    n_depth   = depth_dec;
                    n_drain_v = 1'b1;
                end else begin
                    n_drain_v = 1'b0;
                end
                if (r_drain_v) begin
                    o_dmem.we    = 1'b1;
                    o_dmem.waddr = i_smem_rdata;
                    o_dmem.wdata = {1'b1, upr_pkg::OPEN_PAREN};
                end
                if ((r_depth == '0) && !r_drain_v) begin
                    n_fin = 1'b1;
                end
            end
            upr_pkg::ST_SCAN1: begin
                if (kept_hit) begin
                    n_res.char_out = i_dmem_rdata[7:0];
                    n_next         = r_pa + upr_pkg::CW'(1);
                    n_pv           = 1'b0;
                end else if (at_end) begin
                    n_ptr = r_len;
                end else begin
                    n_pv   = 1'b1;
                    n_pa   = r_next;
                    n_next = r_next + upr_pkg::CW'(1);
                end
            end
            upr_pkg::ST_SCAN2: begin
                if (kept_hit) begin
                    n_ptr           = r_pa;
                    n_res.none_left = 1'b0;
                    n_res.last_kept = 1'b0;
                end else if (at_end) begin
                    n_ptr           = r_len;
                    n_res.none_left = 1'b0;
                    n_res.last_kept = 1'b1;
                end else begin
                    n_pv   = 1'b1;
                    n_pa   = r_next;
                    n_next = r_next + upr_pkg::CW'(1);
                end
            end
            upr_pkg::ST_EMIT: begin
                n_pv = 1'b0;
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= upr_pkg::ST_IDLE;
            r_len     <= '0;
            r_depth   <= '0;
            r_ptr     <= '0;
            r_next    <= '0;
            r_fin     <= 1'b0;
            r_ovf     <= 1'b0;
            r_pv      <= 1'b0;
            r_drain_v <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_depth   <= n_depth;
            r_ptr     <= n_ptr;
            r_next    <= n_next;
            r_fin     <= n_fin;
            r_ovf     <= n_ovf;
            r_pv      <= n_pv;
            r_drain_v <= n_drain_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_res <= n_res;
    end

endmodule

[tb/sv/unmatched_paren_remover_top_tb.sv]
// ---------------------------------------------------------------------------
// unmatched_paren_remover_top_tb: self-checking bench for the paren remover
// Streams strings of bytes and fetch requests into the block. A shadow copy
// of the store, the removal marks and the open-parenthesis stack predicts
// each fetch result that the directed table does not type in by hand, and
// each master transaction is checked against the owed result. A short
// directed table opens the run. Random strings with random bursts,
// receiver stalls, a long receiver hold-off and one overlong string follow.
// ---------------------------------------------------------------------------
module unmatched_paren_remover_top_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int TOTAL_ITEMS    = 1100;   // whole run, overlong string included
    localparam int LONG_STRING    = upr_pkg::MAX_LEN + 6;   // overruns the store
    localparam int LONG_FETCHES   = 6;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 256;
    localparam int DIR_ROWS       = 20;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready one cycle in four on average
        RX_PULSE     // ready on a fixed pattern
    } t_stall;

    // One row of the directed table; known marks a result typed in by hand
    typedef struct packed {
        logic             act;
        logic [7:0]       ch;
        logic             fin;
        logic             known;
        upr_pkg::t_result res;
    } t_stim;

    localparam upr_pkg::t_result NOTHING_LEFT = '{char_out: 8'h00, last_kept: 1'b0,
                                                  none_left: 1'b1, overflowed: 1'b0};
    localparam upr_pkg::t_result UNTYPED      = '0;

    // Directed stimulus: reset state, fetch before finalise, matched and
    // unmatched parentheses, an all-removed string, byte extremes and fetch
    // past the end. Ignored fetch fields are toggled on purpose.
    t_stim dir_tab [DIR_ROWS] = '{
        '{upr_pkg::ACT_FETCH, 8'hFF,                1'b1, 1'b1, NOTHING_LEFT},  // after reset
        '{upr_pkg::ACT_LOAD,  8'h61,                1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'h00,                1'b0, 1'b1, NOTHING_LEFT},  // not finalised
        '{upr_pkg::ACT_LOAD,  upr_pkg::OPEN_PAREN,  1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_LOAD,  8'hFF,                1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_LOAD,  upr_pkg::CLOSE_PAREN, 1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_LOAD,  upr_pkg::CLOSE_PAREN, 1'b0, 1'b0, UNTYPED},  // nothing to match
        '{upr_pkg::ACT_LOAD,  upr_pkg::OPEN_PAREN,  1'b1, 1'b0, UNTYPED},  // open at final
        '{upr_pkg::ACT_FETCH, 8'h00,                1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'hFF,                1'b1, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'h00,                1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'hFF,                1'b1, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'h00,                1'b0, 1'b1, NOTHING_LEFT},  // past the end
        '{upr_pkg::ACT_LOAD,  upr_pkg::CLOSE_PAREN, 1'b1, 1'b0, UNTYPED},  // all removed
        '{upr_pkg::ACT_FETCH, 8'h5A,                1'b1, 1'b1, NOTHING_LEFT},
        '{upr_pkg::ACT_LOAD,  8'h00,                1'b1, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'hA5,                1'b0, 1'b0, UNTYPED},
        '{upr_pkg::ACT_FETCH, 8'h00,                1'b1, 1'b1, NOTHING_LEFT},
        '{upr_pkg::ACT_LOAD,  upr_pkg::OPEN_PAREN,  1'b1, 1'b0, UNTYPED},  // lone open
        '{upr_pkg::ACT_FETCH, 8'hFF,                1'b0, 1'b1, NOTHING_LEFT}
    };

    // Clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    // Slave side, driven by the sender
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       s_tready;

    // Master side, drained by the receiver
    logic       m_tready = 1'b0;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    unmatched_paren_remover_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] char_in
        .i_s_tuser  (s_tuser),    // [0] action
        .i_s_tlast  (s_tlast),    // final_char
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] char_out
        .o_m_tuser  (m_tuser),    // [0] none_left, [1] overflowed
        .o_m_tlast  (m_tlast)     // last_kept
    );

    // -----------------------------------------------------------------------
    // Shadow state of the string being built or read out
    // -----------------------------------------------------------------------
    logic [7:0]             shadow_byte [upr_pkg::MAX_LEN];
    logic                   shadow_drop [upr_pkg::MAX_LEN];
    logic [upr_pkg::AW-1:0] shadow_open [upr_pkg::MAX_LEN];
    logic [upr_pkg::CW-1:0] open_depth = '0;
    logic [upr_pkg::CW-1:0] str_len    = '0;
    logic [upr_pkg::CW-1:0] rd_pos     = '0;
    logic                   str_done   = 1'b0;
    logic                   str_ovf    = 1'b0;

    // Fetch results still owed by the block, oldest first
    upr_pkg::t_result fetch_owed_q [$];
    int               fail_count = 0;
    int               items_sent = 0;

    // Receiver state, shared with the sender for the long hold-off
    int     hold_asks  = 0;
    int     holds_done = 0;
    int     hold_left  = 0;
    int     mode_left  = 0;
    t_stall stall_mode = RX_OPEN;

    // Advance past removed positions; entries at or beyond the length are
    // never looked at, so only bytes of the current string are read.
    function automatic logic [upr_pkg::CW-1:0] skip_dropped(
        input logic [upr_pkg::CW-1:0] from);
        logic [upr_pkg::CW-1:0] p;
        p = from;
        while (p < str_len && shadow_drop[p[upr_pkg::AW-1:0]])
            p = p + upr_pkg::CW'(1);
        return p;
    endfunction

    function automatic int count_kept();
        int n;
        n = 0;
        for (int i = 0; i < int'(str_len); i++)
            if (!shadow_drop[upr_pkg::AW'(i)])
                n++;
        return n;
    endfunction

    // Apply one accepted item to the shadow state. Return 1 with the result
    // for a fetch, 0 for a load.
    function automatic bit predict_strip(input logic act, input logic [7:0] ch,
                                         input logic fin,
                                         output upr_pkg::t_result res);
        logic [upr_pkg::CW-1:0] idx;
        res = '{char_out: 8'h00, last_kept: 1'b0, none_left: 1'b1,
                overflowed: str_ovf};
        if (act == upr_pkg::ACT_LOAD) begin
            // A load after a finished string opens a fresh one
            if (str_done) begin
                open_depth = '0;
                str_len    = '0;
                rd_pos     = '0;
                str_done   = 1'b0;
                str_ovf    = 1'b0;
            end
            if (str_len < upr_pkg::CW'(upr_pkg::MAX_LEN)) begin
                shadow_byte[str_len[upr_pkg::AW-1:0]] = ch;
                shadow_drop[str_len[upr_pkg::AW-1:0]] = 1'b0;
                // The stack never outgrows the string, so a push always fits
                if (ch == upr_pkg::OPEN_PAREN) begin
                    shadow_open[open_depth[upr_pkg::AW-1:0]] = str_len[upr_pkg::AW-1:0];
                    open_depth = open_depth + upr_pkg::CW'(1);
                end else if (ch == upr_pkg::CLOSE_PAREN) begin
                    if (open_depth != '0)
                        open_depth = open_depth - upr_pkg::CW'(1);
                    else
                        shadow_drop[str_len[upr_pkg::AW-1:0]] = 1'b1;
                end
                str_len = str_len + upr_pkg::CW'(1);
            end else begin
                // Store full: drop the byte, but still honour its final flag
                str_ovf = 1'b1;
            end
            if (fin) begin
                while (open_depth != '0) begin
                    open_depth = open_depth - upr_pkg::CW'(1);
                    shadow_drop[shadow_open[open_depth[upr_pkg::AW-1:0]]] = 1'b1;
                end
                rd_pos   = '0;
                str_done = 1'b1;
            end
            return 1'b0;
        end
        if (str_done) begin
            idx = skip_dropped(rd_pos);
            if (idx >= str_len) begin
                rd_pos = str_len;
            end else begin
                res.char_out  = shadow_byte[idx[upr_pkg::AW-1:0]];
                res.none_left = 1'b0;
                rd_pos        = idx + upr_pkg::CW'(1);
                res.last_kept = (skip_dropped(rd_pos) >= str_len);
            end
        end
        return 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // -----------------------------------------------------------------------
    int burst_left = 0;
    bit gapless    = 1'b0;

    task automatic offer_item(input logic act, input logic [7:0] ch, input logic fin,
                              input logic known, input upr_pkg::t_result known_res);
        upr_pkg::t_result res;
        int               gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gapless ? 0 : $urandom_range(0, 6);
            // Lower valid only for a real gap, so it never drops and rises
            // within the same step
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        s_tlast  <= fin;
        // Hold the item until the block takes it
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (predict_strip(act, ch, fin, res))
            fetch_owed_q.push_back(known ? known_res : res);
    endtask

    // Mostly parentheses, so that matching and removal are exercised hard
    function automatic logic [7:0] paren_heavy_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return upr_pkg::OPEN_PAREN;
        else if (pick < 7)
            return upr_pkg::CLOSE_PAREN;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic offer_fetch();
        offer_item(upr_pkg::ACT_FETCH, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b0, UNTYPED);
    endtask

    // One string, then enough fetches to read it out and usually run past
    // its end; now and then stop early so the next load cuts it short.
    task automatic offer_string(input bit with_hold);
        int len;
        int peek_at;
        int fetches;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                              : $urandom_range(1, 12);
        peek_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == peek_at)
                offer_fetch();
            offer_item(upr_pkg::ACT_LOAD, paren_heavy_byte(), i == len - 1,
                       1'b0, UNTYPED);
        end
        fetches = count_kept() + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            fetches = $urandom_range(0, fetches);
        if (with_hold) begin
            // Ask the receiver to hold off and keep offering meanwhile
            hold_asks++;
            fetches += 8;
        end
        repeat (fetches) offer_fetch();
    endtask

    // One string longer than the store: overflow, a dropped final byte
    task automatic offer_long_string();
        for (int i = 0; i < LONG_STRING; i++)
            offer_item(upr_pkg::ACT_LOAD, paren_heavy_byte(), i == LONG_STRING - 1,
                       1'b0, UNTYPED);
        repeat (LONG_FETCHES) offer_fetch();
    endtask

    // -----------------------------------------------------------------------
    // Receiver: stall patterns of its own, plus a long hold-off on request
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_asks) begin
            holds_done <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall'($urandom_range(0, 3));
                mode_left  <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (mode_left % 5 < 2);
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: compare every master transaction with the oldest owed
    // -----------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        upr_pkg::t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (fetch_owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %0h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = fetch_owed_q.pop_front();
                check_field("char_out",   want.char_out,         m_tdata);
                check_field("last_kept",  8'(want.last_kept),    8'(m_tlast));
                check_field("none_left",  8'(want.none_left),    8'(m_tuser[0]));
                check_field("overflowed", 8'(want.overflowed),   8'(m_tuser[1]));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run once nothing has moved for too long
    // -----------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        int budget;
        budget = TOTAL_ITEMS - LONG_STRING - LONG_FETCHES;

        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            offer_item(dir_tab[i].act, dir_tab[i].ch, dir_tab[i].fin,
                       dir_tab[i].known, dir_tab[i].res);

        // Random part: the first string carries the long receiver hold-off
        gapless = 1'b0;
        offer_string(1'b1);
        while (items_sent < budget) begin
            gapless = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 82) begin
                offer_string(1'b0);
            end else begin
                // Noise: arbitrary loads and fetches in any order
                repeat ($urandom_range(1, 6))
                    offer_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               $urandom_range(0, 3) == 0, 1'b0, UNTYPED);
            end
        end
        // The overlong string closes the run
        offer_long_string();
        s_tvalid <= 1'b0;

        // Drain what is owed, then watch a while for stray results
        while (fetch_owed_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
